// ----- rtl/idq_pkg.sv -----
// Shared types and codes for the indexed deque.
package idq_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_INSERT     = 3'd4,
      OP_REMOVE     = 3'd5,
      OP_READ       = 3'd6,
      OP_STATUS     = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_BAD_INDEX = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      op_type      operation;
      logic [3:0]  position;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_word;
      logic [31:0] front_word;
      logic [31:0] back_word;
      logic [4:0]  element_count;
      logic        is_empty_flag;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      logic ins;
      logic del;
      logic rd_en;
   } cell_cmd_type;

endpackage

// ----- rtl/indexed_deque.sv -----
// Indexed deque: one transaction per clock; the request and then the result are registered.
// A transaction accepted with start is held in req_valid_ff and req_ff, then its result
// is registered in rsp_ff and shown, with rsp_valid high, for a single cycle. Throughput: one
// transaction every cycle; busy stays low. The receiver cannot stall.
// Reset clears the element count and pipeline valids; cell contents are not cleared
// and the store reads as empty right after reset.
module indexed_deque import idq_pkg::*; #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic                 req_valid_ff;
   req_type              req_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   cell_cmd_type         cmd;
   logic [IW-1:0]        idx;
   logic [IW-1:0]        rd_idx;
   logic [CW-1:0]        count_next;
   status_type           status;
   logic [WORD_BITS-1:0] rd_word;
   logic [WORD_BITS-1:0] front_word;
   logic [WORD_BITS-1:0] back_word;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   idq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid_ff),
      .req        (req_ff),
      .cmd        (cmd),
      .idx        (idx),
      .rd_idx     (rd_idx),
      .count_next (count_next),
      .status     (status)
   );

   idq_cells #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_cells (
      .clock      (clock),
      .cmd        (cmd),
      .idx        (idx),
      .rd_idx     (rd_idx),
      .count_next (count_next),
      .wr_word    (WORD_BITS'(req_ff.value)),
      .rd_word    (rd_word),
      .front_word (front_word),
      .back_word  (back_word)
   );

   always_comb begin
      rsp_in.read_word     = cmd.rd_en ? 32'(rd_word) : '0;
      rsp_in.front_word    = 32'(front_word);
      rsp_in.back_word     = 32'(back_word);
      rsp_in.element_count = 5'(count_next);
      rsp_in.is_empty_flag = (count_next == '0);
      rsp_in.status        = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      !reset && start && !busy |=> ##1 rsp_valid)
      else $error("accepted transaction produced no result");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty_flag |->
         rsp_data.front_word == '0 && rsp_data.back_word == '0)
      else $error("empty store reported nonzero end words");

endmodule

// ----- rtl/idq_ctrl.sv -----
// Operation decode, index checks, status and element count register.
module idq_ctrl import idq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  req_type                    req,
   output cell_cmd_type               cmd,
   output logic [$clog2(DEPTH)-1:0]   idx,
   output logic [$clog2(DEPTH)-1:0]   rd_idx,
   output logic [$clog2(DEPTH+1)-1:0] count_next,
   output status_type                 status
);

   localparam int IW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 4) ? CW : 4;

   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic [CMPW-1:0] pos_w;
   logic [CMPW-1:0] n_w;
   logic            full;
   logic            empty;
   logic [IW-1:0]   pos_idx;
   logic [IW-1:0]   last_idx;
   logic            ins;
   logic            del;
   logic            rd;

   assign pos_w    = CMPW'(req.position);
   assign n_w      = CMPW'(count_ff);
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pos_idx  = IW'(req.position);
   assign last_idx = IW'(count_ff - CW'(1));

   always_comb begin
      ins    = 1'b0;
      del    = 1'b0;
      rd     = 1'b0;
      idx    = '0;
      rd_idx = '0;
      status = ST_OK;
      case (req.operation)
         OP_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ins = 1'b1;
               idx = IW'(count_ff);
            end
         end
         OP_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ins = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               del    = 1'b1;
               rd     = 1'b1;
               idx    = last_idx;
               rd_idx = last_idx;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               del = 1'b1;
               rd  = 1'b1;
            end
         end
         OP_INSERT: begin
            if (pos_w > n_w) begin
               status = ST_BAD_INDEX;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               ins = 1'b1;
               idx = pos_idx;
            end
         end
         OP_REMOVE: begin
            if (pos_w >= n_w) begin
               status = ST_BAD_INDEX;
            end else begin
               del    = 1'b1;
               rd     = 1'b1;
               idx    = pos_idx;
               rd_idx = pos_idx;
            end
         end
         OP_READ: begin
            if (pos_w >= n_w) begin
               status = ST_BAD_INDEX;
            end else begin
               rd     = 1'b1;
               rd_idx = pos_idx;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign cmd.ins   = req_valid & ins;
   assign cmd.del   = req_valid & del;
   assign cmd.rd_en = rd;

   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.del) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_next = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count above capacity");

   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      req_valid && status != ST_OK |=> count_ff == $past(count_ff))
      else $error("count changed on failed transaction");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> count_ff == $past(count_ff) + CW'(1))
      else $error("count did not grow on insert");

endmodule

// ----- rtl/idq_cells.sv -----
// Position-ordered storage cells; each cell loads, shifts or holds.
module idq_cells import idq_pkg::*; #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                       clock,
   input  cell_cmd_type               cmd,
   input  logic [$clog2(DEPTH)-1:0]   idx,
   input  logic [$clog2(DEPTH)-1:0]   rd_idx,
   input  logic [$clog2(DEPTH+1)-1:0] count_next,
   input  logic [WORD_BITS-1:0]       wr_word,
   output logic [WORD_BITS-1:0]       rd_word,
   output logic [WORD_BITS-1:0]       front_word,
   output logic [WORD_BITS-1:0]       back_word
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WORD_BITS-1:0] cells_ff [DEPTH];
   logic [WORD_BITS-1:0] cells_in [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      always_comb begin
         cells_in[i] = cells_ff[i];
         if (cmd.ins) begin
            if (idx == IW'(i)) begin
               cells_in[i] = wr_word;
            end else if (idx < IW'(i)) begin
               cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (cmd.del) begin
            if (idx <= IW'(i) && i < DEPTH - 1) begin
               cells_in[i] = cells_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end
      end

      always_ff @(posedge clock) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   assign rd_word    = cells_ff[rd_idx];
   assign front_word = (count_next == '0) ? '0 : cells_in[0];
   assign back_word  = (count_next == '0) ? '0 : cells_in[IW'(count_next - CW'(1))];

endmodule
